[rtl/ppcs_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and item types for the piecewise power-curve shaper.
package ppcs_pkg;

  localparam int DEF_MAX_POINTS  = 32;
  localparam int DEF_BEND_MARGIN = 655;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [16:0] ONE16     = 17'd65536;
  localparam logic [22:0] ONE22     = 23'd4194304;
  localparam logic [15:0] BEND_HALF = 16'd32768;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic [15:0] bend;
  } pt_t;

  typedef struct packed {
    logic        op;
    logic        zero;
    logic        neg;
    logic [22:0] mag;
    logic [4:0]  idx;
    pt_t         pt;
  } item_t;

endpackage

[rtl/ppcs_front.sv]
`timescale 1ns / 1ps
// Request intake: clamps breakpoint writes and classifies audio samples.
module ppcs_front import ppcs_pkg::*; #(
  parameter int MAX_POINTS  = DEF_MAX_POINTS,
  parameter int BEND_MARGIN = DEF_BEND_MARGIN
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [4:0]         point_index,
  input  logic [16:0]        point_x,
  input  logic [16:0]        point_y,
  input  logic [16:0]        point_bend,
  input  logic signed [23:0] sample_in,
  input  logic               q_full,
  output logic               q_push,
  output item_t              q_item
);

  localparam logic [16:0] BEND_LO = 17'(BEND_MARGIN);
  localparam logic [16:0] BEND_HI = 17'(65536 - BEND_MARGIN);

  logic [23:0] s_bits;
  logic [23:0] s_mag;
  logic        keep;

  assign in_ready = !q_full;
  assign s_bits   = sample_in;
  assign s_mag    = s_bits[23] ? (24'd0 - s_bits) : s_bits;

  // Writes to the fixed origin or beyond the table are dropped here.
  assign keep   = (op == OP_SAMPLE) ||
                  ((point_index != 5'd0) && (int'(point_index) < MAX_POINTS));
  assign q_push = in_valid && in_ready && keep;

  always_comb begin
    q_item      = '0;
    q_item.op   = op;
    q_item.idx  = point_index;
    q_item.zero = (s_bits == 24'd0);
    q_item.neg  = s_bits[23];
    q_item.mag  = (s_mag > {1'b0, ONE22}) ? ONE22 : s_mag[22:0];
    q_item.pt.x = (point_x > ONE16) ? ONE16 : point_x;
    q_item.pt.y = (point_y > ONE16) ? ONE16 : point_y;
    if (point_bend < BEND_LO) begin
      q_item.pt.bend = BEND_LO[15:0];
    end else if (point_bend > BEND_HI) begin
      q_item.pt.bend = BEND_HI[15:0];
    end else begin
      q_item.pt.bend = point_bend[15:0];
    end
  end

endmodule

[rtl/ppcs_fifo.sv]
`timescale 1ns / 1ps
// Short request queue between the intake and the shaping engine.
module ppcs_fifo import ppcs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item_in,
  output logic  full,
  input  logic  pop,
  output item_t head,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW + 1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/ppcs_back.sv]
`timescale 1ns / 1ps
// Shaping engine: breakpoint table, segment scan, divider, log2, exp2 and output stage.
module ppcs_back import ppcs_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [$clog2(MAX_POINTS):0]   n_pts,
  input  logic                          q_empty,
  input  item_t                         q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [23:0]            sample_out
);

  localparam int AW = $clog2(MAX_POINTS);

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_CMP, S_DIV, S_SEL, S_LGI, S_LOG, S_LGD, S_MUL,
    S_EXI, S_SQI, S_SQ, S_TERM, S_PROD, S_FIN, S_DONE
  } state_t;

  state_t state;

  // Breakpoint table.
  pt_t             mem [MAX_POINTS];
  logic [MAX_POINTS-1:0] pt_ok;
  pt_t             rd_word;
  logic            rd_ok;
  logic            rd_one;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [16:0]     eff_x;
  logic [16:0]     eff_y;
  logic [15:0]     eff_bend;

  // Sample context.
  logic [22:0]   mag;
  logic          neg;
  logic [AW-1:0] i;
  logic [16:0]   prev_x;
  logic [16:0]   prev_y;
  logic [16:0]   yl;
  logic [16:0]   yr;
  logic [15:0]   bend;
  logic [16:0]   r;
  logic          hi;
  logic          up;
  logic [16:0]   dy;
  logic [16:0]   crv;

  // Divider.
  logic [22:0] rem;
  logic [22:0] den;
  logic [15:0] quo;
  logic [3:0]  cnt;
  logic [23:0] rem2;
  logic        div_ge;

  // Logarithm unit.
  logic [16:0] lg_v;
  logic [4:0]  lg_e;
  logic [30:0] lg_z;
  logic [15:0] lg_frac;
  logic        lg_pass;
  logic [4:0]  lg_e0;
  logic [30:0] lg_z0;
  logic [61:0] lg_sq;
  logic [31:0] lg_zz;
  logic [20:0] lg_res;
  logic [20:0] la;
  logic [20:0] lp;

  // Exponent unit with bit-serial square root.
  logic [26:0] ex_e;
  logic [30:0] ex_y;
  logic [3:0]  kbit;
  logic [60:0] sq_n;
  logic [60:0] sq_res;
  logic [60:0] sq_bit;
  logic [60:0] sq_sum;
  logic [60:0] sq_next;
  logic        sq_ge;
  logic [30:0] ex_yh;

  // Output arithmetic.
  logic [16:0] t;
  logic [33:0] dprod;
  logic [23:0] dstep;
  logic [23:0] yl64;
  logic [23:0] yr64;
  logic [23:0] res_mag;
  logic [23:0] res;

  assign q_pop   = (state == S_IDLE) && !q_empty;
  assign wr_en   = q_pop && (q_head.op == OP_WRITE);
  assign wr_addr = AW'(q_head.idx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_head.pt;
    end
    rd_word <= mem[i];
    rd_ok   <= pt_ok[i];
    rd_one  <= (i == AW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_ok <= '0;
    end else if (wr_en) begin
      pt_ok[wr_addr] <= 1'b1;
    end
  end

  // Slots never written read as their reset values.
  assign eff_x    = rd_ok ? rd_word.x : (rd_one ? ONE16 : 17'd0);
  assign eff_y    = rd_ok ? rd_word.y : (rd_one ? ONE16 : 17'd0);
  assign eff_bend = rd_ok ? rd_word.bend : BEND_HALF;

  assign rem2   = {rem, 1'b0};
  assign div_ge = rem2 >= {1'b0, den};

  always_comb begin
    lg_e0 = 5'd0;
    for (int b = 0; b < 17; b++) begin
      if (lg_v[b]) begin
        lg_e0 = 5'(b);
      end
    end
  end

  assign lg_z0  = 31'(lg_v) << (5'd30 - lg_e0);
  assign lg_sq  = {31'd0, lg_z} * {31'd0, lg_z};
  assign lg_zz  = lg_sq[61:30];
  assign lg_res = 21'(1048576) - {lg_e, lg_frac};

  assign ex_yh   = ex_e[kbit] ? (ex_y >> 1) : ex_y;
  assign sq_sum  = sq_res + sq_bit;
  assign sq_ge   = sq_n >= sq_sum;
  assign sq_next = sq_ge ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);

  assign dstep   = 24'((dprod + 34'd512) >> 10);
  assign yl64    = {1'b0, yl, 6'd0};
  assign yr64    = {1'b0, yr, 6'd0};

  always_comb begin
    if (!hi) begin
      res_mag = up ? (yl64 + dstep) : (yl64 - dstep);
    end else begin
      res_mag = up ? (yr64 - dstep) : (yr64 + dstep);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      sample_out <= '0;
    end else begin
      // A result leaving while the next one is presented is handled in S_DONE.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty && (q_head.op == OP_SAMPLE)) begin
            mag <= q_head.mag;
            neg <= q_head.neg;
            i   <= '0;
            if (q_head.zero) begin
              res   <= '0;
              state <= S_DONE;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (i == '0) begin
            prev_x <= eff_x;
            prev_y <= eff_y;
            i      <= AW'(1);
            state  <= S_RD;
          end else if (({eff_x, 6'd0} >= mag) || ({1'b0, i} == n_pts - 1'b1)) begin
            yl   <= prev_y;
            yr   <= eff_y;
            bend <= eff_bend;
            if ((mag >= {eff_x, 6'd0}) || ({eff_x, 6'd0} <= {prev_x, 6'd0})) begin
              r     <= ONE16;
              state <= S_SEL;
            end else begin
              rem   <= mag - {prev_x, 6'd0};
              den   <= {eff_x, 6'd0} - {prev_x, 6'd0};
              quo   <= '0;
              cnt   <= 4'd15;
              state <= S_DIV;
            end
          end else begin
            prev_x <= eff_x;
            prev_y <= eff_y;
            i      <= i + 1'b1;
            state  <= S_RD;
          end
        end
        S_DIV: begin
          rem <= div_ge ? 23'(rem2 - {1'b0, den}) : rem2[22:0];
          quo <= {quo[14:0], div_ge};
          cnt <= cnt - 1'b1;
          if (cnt == 4'd0) begin
            r     <= {1'b0, quo[14:0], div_ge};
            state <= S_SEL;
          end
        end
        S_SEL: begin
          hi  <= bend > BEND_HALF;
          up  <= yr >= yl;
          dy  <= (yr >= yl) ? (yr - yl) : (yl - yr);
          crv <= (bend > BEND_HALF) ? (ONE16 - {1'b0, bend}) : {1'b0, bend};
          lg_v    <= (bend > BEND_HALF) ? (ONE16 - r) : r;
          lg_pass <= 1'b0;
          if (((bend > BEND_HALF) ? (ONE16 - r) : r) == 17'd0) begin
            t     <= '0;
            state <= S_PROD;
          end else begin
            state <= S_LGI;
          end
        end
        S_LGI: begin
          lg_e    <= lg_e0;
          lg_z    <= lg_z0;
          lg_frac <= '0;
          cnt     <= 4'd15;
          state   <= S_LOG;
        end
        S_LOG: begin
          // Squaring the mantissa yields one fraction bit per step.
          if (lg_zz[31]) begin
            lg_z         <= lg_zz[31:1];
            lg_frac[cnt] <= 1'b1;
          end else begin
            lg_z <= lg_zz[30:0];
          end
          cnt <= cnt - 1'b1;
          if (cnt == 4'd0) begin
            state <= S_LGD;
          end
        end
        S_LGD: begin
          if (!lg_pass) begin
            la      <= lg_res;
            lg_v    <= crv;
            lg_pass <= 1'b1;
            state   <= S_LGI;
          end else begin
            lp    <= lg_res;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          ex_e  <= 27'((({21'd0, la} * {21'd0, lp}) + 42'd32768) >> 16);
          state <= S_EXI;
        end
        S_EXI: begin
          if (ex_e[26:16] > 11'd16) begin
            t     <= '0;
            state <= S_PROD;
          end else begin
            ex_y  <= 31'd1073741824;
            kbit  <= 4'd0;
            state <= S_SQI;
          end
        end
        S_SQI: begin
          sq_n   <= 61'(ex_yh) << 30;
          sq_res <= '0;
          sq_bit <= 61'd1 << 60;
          state  <= S_SQ;
        end
        S_SQ: begin
          if (sq_ge) begin
            sq_n <= sq_n - sq_sum;
          end
          sq_res <= sq_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 61'd1) begin
            ex_y <= sq_next[30:0];
            if (kbit == 4'd15) begin
              state <= S_TERM;
            end else begin
              kbit  <= kbit + 1'b1;
              state <= S_SQI;
            end
          end
        end
        S_TERM: begin
          t     <= 17'(({1'b0, ex_y >> ex_e[20:16]} + 32'd8192) >> 14);
          state <= S_PROD;
        end
        S_PROD: begin
          dprod <= {17'd0, t} * {17'd0, dy};
          state <= S_FIN;
        end
        S_FIN: begin
          res   <= neg ? (24'd0 - res_mag) : res_mag;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            sample_out <= signed'(res);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_log_norm: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOG) |-> (lg_z[30] == 1'b1))
    else $error("log mantissa lost normalization");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ({1'b0, i} <= n_pts - 1'b1))
    else $error("segment scan ran past last point in use");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((sample_out <= 24'sd4194304) && (sample_out >= -24'sd4194304)))
    else $error("output magnitude above full scale");

endmodule

[rtl/piecewise_power_curve_shaper.sv]
`timescale 1ns / 1ps
// Top level of the odd-symmetric piecewise power-curve waveshaper.
//
// Requests come in two kinds: a breakpoint write (op low) stores x, y and bend
// for one slot, and a sample request (op high) returns one shaped sample. An
// intake stage clamps and classifies each request and drops writes to the
// origin or past the table; a two-entry queue then feeds the shaping engine,
// so new requests are taken, while the queue has room, as the engine works or
// while a result waits at the output. Requests are executed strictly in order,
// so a write always affects the samples behind it. A nonzero sample leaves the
// queue, then runs the segment scan (one table read and compare per point),
// the fraction divider where needed, a step that picks the side of the curve,
// the two logarithms, the exponent product, the exponential (sixteen square
// roots, each one result bit per cycle) and the finishing steps; the square
// roots make up most of the work. A zero sample goes straight to the output.
// The points_in_use register is written through cfg_wr_en and cfg_wr_data;
// the user must write it only while the block is idle, as the block itself
// does not enforce this. It is used clamped to the range from two to
// MAX_POINTS.
module piecewise_power_curve_shaper import ppcs_pkg::*; #(
  parameter int MAX_POINTS  = DEF_MAX_POINTS,
  parameter int BEND_MARGIN = DEF_BEND_MARGIN
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [5:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [4:0]         point_index,
  input  logic [16:0]        point_x,
  input  logic [16:0]        point_y,
  input  logic [16:0]        point_bend,
  input  logic signed [23:0] sample_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] sample_out
);

  localparam int NW = $clog2(MAX_POINTS) + 1;

  logic [5:0]    points_in_use;
  logic [NW-1:0] n_eff;
  logic          q_full;
  logic          q_push;
  item_t         q_item;
  logic          q_pop;
  item_t         q_head;
  logic          q_empty;

  // The point count register; reset leaves the origin plus one point.
  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= 6'd2;
    end else if (cfg_wr_en) begin
      points_in_use <= cfg_wr_data;
    end
  end

  // The engine sees the count clamped to the range from two to what the table can hold.
  always_comb begin
    if (points_in_use < 6'd2) begin
      n_eff = NW'(2);
    end else if (int'(points_in_use) > MAX_POINTS) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = NW'(points_in_use);
    end
  end

  ppcs_front #(
    .MAX_POINTS  (MAX_POINTS),
    .BEND_MARGIN (BEND_MARGIN)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .point_index (point_index),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_bend  (point_bend),
    .sample_in   (sample_in),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_item)
  );

  ppcs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .item_in (q_item),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  ppcs_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .n_pts      (n_eff),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

endmodule
